// ----- design/wts_pkg.sv -----
// Shared types, command and register codes, and the instrument wave tables
// for the two-voice wavetable sequencer. No dependencies.
package wts_pkg;

  localparam int TABLE_COUNT = 5;
  localparam int TABLE_LEN   = 64;
  localparam int SAMPLE_W    = 12;
  localparam int ENTRY_W     = 25;
  localparam int PERIOD_W    = 16;
  localparam int DIV_W       = 40;   // note duration width, also divider dividend width
  localparam int BEAT_W      = 34;   // clocks per beat: (clock / tempo) * 60
  localparam int Q1_W        = 28;   // clock / tempo

  // Command codes
  localparam logic [1:0] CMD_MELODY  = 2'd0;
  localparam logic [1:0] CMD_HARMONY = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;
  localparam logic [1:0] CMD_REWIND  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_TEMPO       = 2'd0;
  localparam logic [1:0] REG_MELODY_LEN  = 2'd1;
  localparam logic [1:0] REG_HARMONY_LEN = 2'd2;
  localparam logic [1:0] REG_INSTR       = 2'd3;

  typedef struct packed {
    logic [9:0] tempo_bpm;
    logic [8:0] melody_length;
    logic [8:0] harmony_length;
    logic [2:0] instrument_select;
  } cfg_t;

  // One decoded command as it travels through the queue
  typedef struct packed {
    logic [1:0]         cmd;
    logic               voice;
    logic [7:0]         idx;
    logic [ENTRY_W-1:0] entry;
  } op_t;

  typedef struct packed {
    logic [10:0]         dac_sample;
    logic [PERIOD_W-1:0] next_period;
    logic                note_advanced;
    logic                voice_finished;
    logic                song_finished;
  } result_t;

  localparam logic [11:0] WAVE_ROM [TABLE_COUNT*TABLE_LEN] = '{
    // sine
    12'd2048,12'd2224,12'd2399,12'd2571,12'd2737,12'd2897,12'd3048,12'd3190,
    12'd3321,12'd3439,12'd3545,12'd3635,12'd3711,12'd3770,12'd3813,12'd3839,
    12'd3848,12'd3839,12'd3813,12'd3770,12'd3711,12'd3635,12'd3545,12'd3439,
    12'd3321,12'd3190,12'd3048,12'd2897,12'd2737,12'd2571,12'd2399,12'd2224,
    12'd2048,12'd1872,12'd1697,12'd1525,12'd1359,12'd1199,12'd1048,12'd906,
    12'd775,12'd657,12'd551,12'd461,12'd385,12'd326,12'd283,12'd257,
    12'd248,12'd257,12'd265,12'd300,12'd385,12'd461,12'd551,12'd657,
    12'd775,12'd906,12'd1048,12'd1199,12'd1359,12'd1525,12'd1697,12'd1872,
    // trumpet
    12'd2014,12'd2176,12'd2312,12'd2388,12'd2134,12'd1578,12'd606,12'd198,
    12'd1578,12'd3020,12'd2952,12'd2346,12'd2134,12'd2074,12'd2168,12'd2124,
    12'd2022,12'd2030,12'd2090,12'd2124,12'd2022,12'd2022,12'd2116,12'd2226,
    12'd2168,12'd2150,12'd2158,12'd2210,12'd2176,12'd2098,12'd2030,12'd2090,
    12'd2014,12'd2176,12'd2312,12'd2388,12'd2134,12'd1578,12'd606,12'd198,
    12'd1578,12'd3020,12'd2952,12'd2346,12'd2134,12'd2074,12'd2168,12'd2124,
    12'd2022,12'd2030,12'd2090,12'd2124,12'd2022,12'd2022,12'd2116,12'd2226,
    12'd2168,12'd2150,12'd2158,12'd2210,12'd2176,12'd2098,12'd2030,12'd2090,
    // flute
    12'd2014,12'd2504,12'd2748,12'd3096,12'd3396,12'd3594,12'd3650,12'd3594,
    12'd3350,12'd3124,12'd2766,12'd2438,12'd2184,12'd2014,12'd1826,12'd1780,
    12'd1666,12'd1694,12'd1620,12'd1554,12'd1488,12'd1348,12'd1196,12'd1102,
    12'd1018,12'd952,12'd990,12'd1066,12'd1178,12'd1318,12'd1516,12'd1752,
    12'd2014,12'd2504,12'd2748,12'd3096,12'd3396,12'd3594,12'd3650,12'd3594,
    12'd3350,12'd3124,12'd2766,12'd2438,12'd2184,12'd2014,12'd1826,12'd1780,
    12'd1666,12'd1694,12'd1620,12'd1554,12'd1488,12'd1348,12'd1196,12'd1102,
    12'd1018,12'd952,12'd990,12'd1066,12'd1178,12'd1318,12'd1516,12'd1752,
    // guitar
    12'd2048,12'd2048,12'd2052,12'd2003,12'd1869,12'd1665,12'd1459,12'd1293,
    12'd1238,12'd1332,12'd1563,12'd1928,12'd2343,12'd2673,12'd2922,12'd3073,
    12'd3116,12'd3005,12'd2792,12'd2471,12'd2080,12'd1728,12'd1510,12'd1517,
    12'd1754,12'd2175,12'd2716,12'd3227,12'd3579,12'd3692,12'd3544,12'd3250,
    12'd2907,12'd2571,12'd2347,12'd2193,12'd2103,12'd2067,12'd2054,12'd2072,
    12'd2157,12'd2273,12'd2367,12'd2494,12'd2527,12'd2500,12'd2363,12'd2163,
    12'd1948,12'd1731,12'd1602,12'd1557,12'd1621,12'd1689,12'd1717,12'd1718,
    12'd1701,12'd1698,12'd1750,12'd1843,12'd1954,12'd2048,12'd2048,12'd2048,
    // oboe
    12'd2126,12'd2164,12'd2238,12'd2550,12'd3356,12'd3496,12'd2550,12'd1510,
    12'd1322,12'd1322,12'd1406,12'd1462,12'd1538,12'd1690,12'd2078,12'd2268,
    12'd2418,12'd2664,12'd2930,12'd3090,12'd2854,12'd3176,12'd2740,12'd2172,
    12'd1416,12'd1038,12'd896,12'd980,12'd1132,12'd1368,12'd1604,12'd1984,
    12'd2126,12'd2164,12'd2238,12'd2550,12'd3356,12'd3496,12'd2550,12'd1510,
    12'd1322,12'd1322,12'd1406,12'd1462,12'd1538,12'd1690,12'd2078,12'd2268,
    12'd2418,12'd2664,12'd2930,12'd3090,12'd2854,12'd3176,12'd2740,12'd2172,
    12'd1416,12'd1038,12'd896,12'd980,12'd1132,12'd1368,12'd1604,12'd1984
  };

  function automatic logic [11:0] wave_lookup(input logic [2:0] tbl, input logic [5:0] idx);
    return WAVE_ROM[{tbl, idx}];
  endfunction

endpackage

// ----- design/wts_front.sv -----
// Front end: accepts input items and decodes them into queue entries.
// Depends on wts_pkg.
module wts_front import wts_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic        load_voice,
  input  logic [7:0]  load_index,
  input  logic [15:0] load_period,
  input  logic [7:0]  load_length,
  input  logic        load_rest,
  input  logic        q_full,
  output logic        q_push,
  output op_t         q_data
);

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify: ticks carry their voice in the command code, loads in load_voice
  always_comb begin
    q_data.cmd   = command;
    q_data.idx   = load_index;
    q_data.entry = {load_rest, load_length, load_period};
    case (command)
      CMD_MELODY:  q_data.voice = 1'b0;
      CMD_HARMONY: q_data.voice = 1'b1;
      CMD_LOAD:    q_data.voice = load_voice;
      default:     q_data.voice = 1'b0;
    endcase
  end

endmodule

// ----- design/wts_queue.sv -----
// Two-entry queue of decoded commands between front and back end.
// Depends on wts_pkg.
module wts_queue import wts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  head
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/wts_div.sv -----
// Restoring divider, one quotient bit per cycle, used for note durations.
// Depends on wts_pkg.
module wts_div import wts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [PERIOD_W-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic                running;
  logic [PERIOD_W:0]   rem_sh;
  logic                fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (running) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? PERIOD_W'(rem_sh - {1'b0, divisor}) : rem_sh[PERIOD_W-1:0];
    end
  end

endmodule

// ----- design/wts_back.sv -----
// Back end: executes ticks, loads and rewinds against the note store and the
// voice state, computes note durations and holds the result register.
// Depends on wts_pkg and wts_div.
module wts_back import wts_pkg::*; #(
  parameter int CLOCK_HZ          = 80000000,
  parameter int WAVE_DEPTH        = 64,
  parameter int NOTE_DEPTH        = 256,
  parameter int VOICE_COUNT_INSTR = 5
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  op_t     q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  localparam int IW = $clog2(NOTE_DEPTH);
  localparam int AW = IW + 1;
  localparam int PW = IW + 1;
  localparam int SW = $clog2(WAVE_DEPTH);
  localparam int LAST_TBL = (VOICE_COUNT_INSTR < TABLE_COUNT ?
                             VOICE_COUNT_INSTR : TABLE_COUNT) - 1;
  localparam logic [DIV_W-1:0] CLK_VAL = DIV_W'(CLOCK_HZ);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_TICK = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_EXEC = 10'b0000001000,
    S_DUR  = 10'b0000010000,
    S_DIVA = 10'b0000100000,
    S_MUL  = 10'b0001000000,
    S_DIVB = 10'b0010000000,
    S_RWV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state;
  op_t    op;
  logic   cv;
  logic   rd_exec;

  // Note store
  logic [ENTRY_W-1:0] mem [2*NOTE_DEPTH];
  logic [AW-1:0]      addr;
  logic [ENTRY_W-1:0] rdata;

  // Voice state
  logic [PW-1:0]       pos     [2];
  logic [SW-1:0]       step    [2];
  logic [DIV_W-1:0]    elapsed [2];
  logic [DIV_W-1:0]    dur     [2];
  logic [SAMPLE_W-1:0] smp     [2];
  logic                end_flag;

  // Result fields being built
  logic                adv;
  logic                fin;
  logic [PERIOD_W-1:0] np;

  // Duration arithmetic
  logic [7:0]          len_q;
  logic [PERIOD_W-1:0] per_q;
  logic [BEAT_W-1:0]   beat;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;

  // Current voice view
  logic [PW-1:0]    n_cur;
  logic [PW-1:0]    pos_cur;
  logic [PW-1:0]    pos_inc;
  logic [SW-1:0]    step_cur;
  logic [SW-1:0]    step_inc;
  logic [DIV_W-1:0] el_inc;
  logic [2:0]       tbl_sel;
  logic [5:0]       tbl_idx;
  logic [9:0]       tempo1;

  wts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic logic [PW-1:0] sat_len(input logic [8:0] l);
    return (32'(l) > NOTE_DEPTH) ? PW'(NOTE_DEPTH) : PW'(l);
  endfunction

  always_comb begin
    n_cur    = sat_len(cv ? cfg.harmony_length : cfg.melody_length);
    pos_cur  = pos[cv];
    pos_inc  = pos_cur + 1'b1;
    step_cur = step[cv];
    step_inc = (32'(step_cur) + 1 == WAVE_DEPTH) ? '0 : SW'(32'(step_cur) + 1);
    el_inc   = elapsed[cv] + 1'b1;
    tbl_sel  = (32'(cfg.instrument_select) > LAST_TBL) ? 3'(LAST_TBL) : cfg.instrument_select;
    tbl_idx  = 6'(32'(step_cur) % TABLE_LEN);
    tempo1   = (cfg.tempo_bpm == '0) ? 10'd1 : cfg.tempo_bpm;
  end

  assign q_pop = (state == S_IDLE) && !q_empty;

  // Note store write on load, registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_head.cmd == CMD_LOAD) begin
      mem[{q_head.voice, IW'(32'(q_head.idx) % NOTE_DEPTH)}] <= q_head.entry;
    end
    if (state == S_RD) begin
      rdata <= mem[addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      end_flag  <= 1'b0;
      for (int v = 0; v < 2; v++) begin
        pos[v]     <= '0;
        step[v]    <= '0;
        elapsed[v] <= '0;
        dur[v]     <= '0;
        smp[v]     <= '0;
      end
    end else begin
      // Kick the divider in the cycle after S_DUR or S_MUL, together with the operands they set up
      div_start <= (state == S_DUR) || (state == S_MUL);
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op  <= q_head;
            cv  <= q_head.voice;
            adv <= 1'b0;
            fin <= 1'b0;
            np  <= '0;
            case (q_head.cmd)
              CMD_LOAD: state <= S_OUT;
              CMD_REWIND: begin
                for (int v = 0; v < 2; v++) begin
                  pos[v]     <= '0;
                  step[v]    <= '0;
                  elapsed[v] <= '0;
                  smp[v]     <= '0;
                end
                end_flag <= 1'b0;
                state    <= S_RWV;
              end
              default: state <= S_TICK;
            endcase
          end
        end
        // Finished voice outputs zero, otherwise fetch its current note
        S_TICK: begin
          if (pos_cur >= n_cur) begin
            smp[cv]  <= '0;
            fin      <= 1'b1;
            end_flag <= 1'b1;
            state    <= S_OUT;
          end else begin
            addr    <= {cv, pos_cur[IW-1:0]};
            rd_exec <= 1'b1;
            state   <= S_RD;
          end
        end
        S_RD: state <= rd_exec ? S_EXEC : S_DUR;
        // Play or rest, count, and advance when the note expires
        S_EXEC: begin
          if (!rdata[ENTRY_W-1]) begin
            smp[cv] <= wave_lookup(tbl_sel, tbl_idx);
          end
          if (el_inc >= dur[cv]) begin
            adv        <= 1'b1;
            pos[cv]    <= pos_inc;
            step[cv]   <= '0;
            elapsed[cv] <= '0;
            if (pos_inc >= n_cur) begin
              dur[cv]  <= '0;
              fin      <= 1'b1;
              end_flag <= 1'b1;
              state    <= S_OUT;
            end else begin
              addr    <= {cv, pos_inc[IW-1:0]};
              rd_exec <= 1'b0;
              state   <= S_RD;
            end
          end else begin
            elapsed[cv] <= el_inc;
            if (!rdata[ENTRY_W-1]) step[cv] <= step_inc;
            state <= S_OUT;
          end
        end
        // Start clock / tempo
        S_DUR: begin
          if (op.cmd != CMD_REWIND) np <= rdata[PERIOD_W-1:0];
          len_q        <= rdata[23:16];
          per_q        <= (rdata[PERIOD_W-1:0] == '0) ? PERIOD_W'(1) : rdata[PERIOD_W-1:0];
          div_dividend <= CLK_VAL;
          div_divisor  <= PERIOD_W'(tempo1);
          state        <= S_DIVA;
        end
        S_DIVA: begin
          if (div_done) begin
            beat  <= BEAT_W'(div_q[Q1_W-1:0] * 6'd60);
            state <= S_MUL;
          end
        end
        // Scale by length / 4, then divide by the period
        S_MUL: begin
          div_dividend <= DIV_W'((BEAT_W+8)'(beat * len_q) >> 2);
          div_divisor  <= per_q;
          state        <= S_DIVB;
        end
        S_DIVB: begin
          if (div_done) begin
            dur[cv] <= div_q;
            if (op.cmd == CMD_REWIND && !cv) begin
              cv    <= 1'b1;
              state <= S_RWV;
            end else begin
              state <= S_OUT;
            end
          end
        end
        // Rewind: load each voice's first duration
        S_RWV: begin
          if (n_cur != '0) begin
            addr    <= {cv, IW'(0)};
            rd_exec <= 1'b0;
            state   <= S_RD;
          end else begin
            dur[cv] <= '0;
            if (!cv) cv <= 1'b1;
            else     state <= S_OUT;
          end
        end
        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid || out_ready) begin
            res.dac_sample     <= 11'(({1'b0, smp[0]} + {1'b0, smp[1]}) >> 2);
            res.next_period    <= np;
            res.note_advanced  <= adv;
            res.voice_finished <= fin;
            res.song_finished  <= end_flag;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/two_voice_wavetable_sequencer_top.sv -----
// Top level of the two-voice wavetable sequencer: configuration registers,
// front end, command queue and back end. Depends on wts_pkg, wts_front, wts_queue and wts_back.
//
// Each input command yields one result. A load goes straight to the output
// register, a tick on a finished voice checks its position first, and a tick
// that stays on its note or runs off the list end also reads the note store;
// a tick that moves to a new note and a rewind may also wait on the shared
// one-bit-per-cycle divider, which computes each duration as (clock / tempo)
// and then (beat * length / 4) / period with a 40-bit dividend. A two-entry
// queue lets new commands be accepted while one executes and a result waits
// in the output register. NOTE_DEPTH must be a power of two; the note store
// holds 2 * NOTE_DEPTH entries and reads undefined where never loaded.
module two_voice_wavetable_sequencer_top import wts_pkg::*; #(
  parameter int CLOCK_HZ          = 80000000,
  parameter int WAVE_DEPTH        = 64,
  parameter int NOTE_DEPTH        = 256,
  parameter int VOICE_COUNT_INSTR = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic        load_voice,
  input  logic [7:0]  load_index,
  input  logic [15:0] load_period,
  input  logic [7:0]  load_length,
  input  logic        load_rest,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] dac_sample,
  output logic [15:0] next_period,
  output logic        note_advanced,
  output logic        voice_finished,
  output logic        song_finished
);

  cfg_t    cfg;
  op_t     q_in;
  op_t     q_head;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  result_t res;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tempo_bpm         <= 10'd120;
      cfg.melody_length     <= 9'd0;
      cfg.harmony_length    <= 9'd0;
      cfg.instrument_select <= 3'd3;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TEMPO:       cfg.tempo_bpm         <= pwdata[9:0];
        REG_MELODY_LEN:  cfg.melody_length     <= pwdata[8:0];
        REG_HARMONY_LEN: cfg.harmony_length    <= pwdata[8:0];
        REG_INSTR:       cfg.instrument_select <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_TEMPO:       prdata = 32'(cfg.tempo_bpm);
      REG_MELODY_LEN:  prdata = 32'(cfg.melody_length);
      REG_HARMONY_LEN: prdata = 32'(cfg.harmony_length);
      REG_INSTR:       prdata = 32'(cfg.instrument_select);
      default:         prdata = '0;
    endcase
  end

  wts_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .load_voice  (load_voice),
    .load_index  (load_index),
    .load_period (load_period),
    .load_length (load_length),
    .load_rest   (load_rest),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  wts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  wts_back #(
    .CLOCK_HZ          (CLOCK_HZ),
    .WAVE_DEPTH        (WAVE_DEPTH),
    .NOTE_DEPTH        (NOTE_DEPTH),
    .VOICE_COUNT_INSTR (VOICE_COUNT_INSTR)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign dac_sample     = res.dac_sample;
  assign next_period    = res.next_period;
  assign note_advanced  = res.note_advanced;
  assign voice_finished = res.voice_finished;
  assign song_finished  = res.song_finished;

endmodule

// ----- design/wts_checker.sv -----
// Port-level checks for the sequencer top level, and the bind that attaches
// them. Depends on wts_pkg and two_voice_wavetable_sequencer_top.
module wts_checker import wts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] dac_sample,
  input logic [15:0] next_period,
  input logic        note_advanced,
  input logic        voice_finished,
  input logic        song_finished
);

  // Hold a stalled result: valid, sample and period stay
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dac_sample) && $stable(next_period))
    else $error("result changed while stalled");

  // A finished voice sets the sticky end flag
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && voice_finished |-> song_finished)
    else $error("voice finished without song end flag");

  // A new period is reported only on an advance inside the list
  a_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && next_period != 16'd0 |-> note_advanced && !voice_finished)
    else $error("period reported without advance");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_voice_wavetable_sequencer_top wts_checker u_wts_checker (.*);

// ----- tb/sv/two_voice_wavetable_sequencer_top_test.sv -----
// Self-checking regression for the two-voice wavetable sequencer top level.
// Holds its own note, duration and sample predictor; depends on wts_pkg and the RTL.
`timescale 1ns / 1ps

module two_voice_wavetable_sequencer_top_test;
  import wts_pkg::*;

  localparam int NOTES = 256;
  localparam longint unsigned CLK_HZ = 80000000;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [1:0]  command;
  logic        load_voice;
  logic [7:0]  load_index;
  logic [15:0] load_period;
  logic [7:0]  load_length;
  logic        load_rest;
  logic        out_valid, out_ready;
  logic [10:0] dac_sample;
  logic [15:0] next_period;
  logic        note_advanced, voice_finished, song_finished;

  two_voice_wavetable_sequencer_top dut (.*);

  // Predictor state: configuration and both voices
  logic [9:0]         tempo_q;
  logic [8:0]         len_q [2];
  logic [2:0]         instr_q;
  logic [ENTRY_W-1:0] notes_q [2*NOTES];
  bit                 loaded_q [2*NOTES];
  int unsigned        pos_q [2];
  logic [5:0]         step_q [2];
  logic [39:0]        elapsed_q [2];
  logic [39:0]        dur_q [2];
  logic [11:0]        smp_q [2];
  logic               end_q;

  result_t     pending_results [$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          advances = 0;
  bit          quiet = 0;
  bit          hold_req = 0;

  // Clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Hard limit on run time
  initial begin
    #20ms;
    $display("two_voice_wavetable_sequencer_top regression: fail");
    $finish;
  end

  function automatic int unsigned eff_len(input int v);
    return (len_q[v] > NOTES) ? NOTES : len_q[v];
  endfunction

  function automatic logic [39:0] note_ticks(input logic [ENTRY_W-1:0] e);
    longint unsigned t, per, len, beat;
    t = (tempo_q == 0) ? 1 : tempo_q;
    per = (e[15:0] == 0) ? 1 : e[15:0];
    len = e[23:16];
    beat = (CLK_HZ / t) * 60;
    return ((beat * len / 4) / per);
  endfunction

  // Compute the expected result of one accepted command
  task automatic predict(input logic [1:0] cmd, input logic voice, input logic [7:0] idx,
                         input logic [15:0] per, input logic [7:0] len, input logic rest);
    result_t r;
    int v;
    int unsigned n, tbl;
    logic [ENTRY_W-1:0] e, ne;
    r = '0;
    if (cmd == CMD_MELODY || cmd == CMD_HARMONY) begin
      v = (cmd == CMD_HARMONY);
      n = eff_len(v);
      if (pos_q[v] >= n) begin
        smp_q[v] = 0;
        r.voice_finished = 1;
      end else begin
        e = notes_q[v*NOTES + pos_q[v]];
        if (!e[24]) begin
          tbl = (instr_q > 4) ? 4 : instr_q;
          smp_q[v] = WAVE_ROM[tbl*TABLE_LEN + step_q[v]];
          step_q[v] = step_q[v] + 1;
        end
        elapsed_q[v] = elapsed_q[v] + 1;
        if (elapsed_q[v] >= dur_q[v]) begin
          r.note_advanced = 1;
          advances++;
          pos_q[v]++;
          step_q[v] = 0;
          elapsed_q[v] = 0;
          if (pos_q[v] >= n) begin
            dur_q[v] = 0;
            r.voice_finished = 1;
          end else begin
            ne = notes_q[v*NOTES + pos_q[v]];
            dur_q[v] = note_ticks(ne);
            r.next_period = ne[15:0];
          end
        end
      end
      if (r.voice_finished) end_q = 1;
    end else if (cmd == CMD_LOAD) begin
      notes_q[voice*NOTES + idx] = {rest, len, per};
      loaded_q[voice*NOTES + idx] = 1;
    end else begin
      for (int i = 0; i < 2; i++) begin
        pos_q[i] = 0;
        step_q[i] = 0;
        elapsed_q[i] = 0;
        smp_q[i] = 0;
        dur_q[i] = eff_len(i) ? note_ticks(notes_q[i*NOTES]) : 0;
      end
      end_q = 0;
    end
    r.dac_sample = (smp_q[0] + smp_q[1]) / 4;
    r.song_finished = end_q;
    pending_results.push_back(r);
  endtask

  // Offer one command and hold it until the transfer
  task automatic send_item(input logic [1:0] cmd, input logic voice, input logic [7:0] idx,
                           input logic [15:0] per, input logic [7:0] len, input logic rest);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1;
    command     <= cmd;
    load_voice  <= voice;
    load_index  <= idx;
    load_period <= per;
    load_length <= len;
    load_rest   <= rest;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(cmd, voice, idx, per, len, rest);
    sent++;
  endtask

  // Random note content, mostly short notes so that voices advance
  task automatic load_note(input logic voice, input logic [7:0] idx);
    logic [15:0] per;
    logic [7:0]  len;
    per = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(32768, 65535)) : 16'($urandom);
    len = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 2)) : 8'($urandom);
    send_item(CMD_LOAD, voice, idx, per, len, $urandom_range(0, 3) == 0);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70)
      send_item(k[0] ? CMD_HARMONY : CMD_MELODY, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    else if (k < 92)
      load_note($urandom, $urandom);
    else if (k < 98)
      send_item(CMD_REWIND, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write in setup and access phases; call only while idle
  task automatic reg_write(input logic [1:0] ridx, input logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    case (ridx)
      REG_TEMPO:       tempo_q = val[9:0];
      REG_MELODY_LEN:  len_q[0] = val[8:0];
      REG_HARMONY_LEN: len_q[1] = val[8:0];
      REG_INSTR:       instr_q = val[2:0];
    endcase
  endtask

  // Fill every unloaded note below the new length, then write the length
  task automatic set_list_len(input int v, input int unsigned val);
    int unsigned n;
    n = (val[8:0] > NOTES) ? NOTES : val[8:0];
    for (int i = 0; i < n; i++)
      if (!loaded_q[v*NOTES + i]) load_note(v, i);
    drain();
    reg_write(v ? REG_HARMONY_LEN : REG_MELODY_LEN, val);
  endtask

  // Receiver: random ready bursts, a long hold on request, none when quiet
  initial begin
    out_ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (quiet) begin
        out_ready <= 1;
        @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
          out_ready <= 0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        x = pending_results.pop_front();
        checked++;
        if (dac_sample !== x.dac_sample) begin
          $error("dac_sample expected %0d got %0d", x.dac_sample, dac_sample);
          errors++;
        end
        if (next_period !== x.next_period) begin
          $error("next_period expected %0d got %0d", x.next_period, next_period);
          errors++;
        end
        if (note_advanced !== x.note_advanced) begin
          $error("note_advanced expected %0d got %0d", x.note_advanced, note_advanced);
          errors++;
        end
        if (voice_finished !== x.voice_finished) begin
          $error("voice_finished expected %0d got %0d", x.voice_finished, voice_finished);
          errors++;
        end
        if (song_finished !== x.song_finished) begin
          $error("song_finished expected %0d got %0d", x.song_finished, song_finished);
          errors++;
        end
      end
    end
  end

  // Directed: empty lists, load extremes, rests, zero period, instruments, tempo 1023 and 0
  task automatic test_directed();
    send_item(CMD_MELODY, 0, 0, 0, 0, 0);
    send_item(CMD_HARMONY, 1, 8'hFF, 16'hFFFF, 8'hFF, 1);
    send_item(CMD_REWIND, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD, 0, 0, 16'hFFFF, 8'd0, 0);
    send_item(CMD_LOAD, 0, 1, 16'd0, 8'd1, 0);
    send_item(CMD_LOAD, 1, 0, 16'd1, 8'd0, 1);
    send_item(CMD_LOAD, 1, 1, 16'hFFFF, 8'd1, 0);
    send_item(CMD_LOAD, 1, 8'hFF, 16'hFFFF, 8'hFF, 1);
    drain();
    reg_write(REG_TEMPO, 32'd1023);
    set_list_len(0, 2);
    set_list_len(1, 2);
    reg_write(REG_INSTR, 32'd0);
    send_item(CMD_REWIND, 0, 0, 0, 0, 0);
    repeat (4) send_item(CMD_MELODY, 0, 0, 0, 0, 0);
    repeat (4) send_item(CMD_HARMONY, 0, 0, 0, 0, 0);
    drain();
    reg_write(REG_INSTR, 32'd7);
    reg_write(REG_TEMPO, 32'd0);
    send_item(CMD_REWIND, 0, 0, 0, 0, 0);
    send_item(CMD_MELODY, 0, 0, 0, 0, 0);
    send_item(CMD_HARMONY, 0, 0, 0, 0, 0);
    drain();
  endtask

  // Random phases with changing tempo, instrument and list lengths
  task automatic test_random_phases(input int stop_at);
    int unsigned t;
    while (sent < stop_at) begin
      t = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(600, 1023);
      reg_write(REG_TEMPO, t);
      reg_write(REG_INSTR, $urandom_range(0, 7));
      set_list_len(0, $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8));
      set_list_len(1, $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8));
      send_item(CMD_REWIND, $urandom, $urandom, $urandom, $urandom, $urandom);
      repeat (60) random_item();
      drain();
    end
  endtask

  // Full-length lists, the harmony list also set above the store depth
  task automatic test_full_lists();
    reg_write(REG_TEMPO, 32'd1023);
    set_list_len(0, 256);
    set_list_len(1, 300);
    send_item(CMD_REWIND, 0, 0, 0, 0, 0);
    repeat (80) random_item();
    drain();
    set_list_len(1, 511);
    send_item(CMD_REWIND, 0, 0, 0, 0, 0);
    repeat (20) random_item();
    drain();
  endtask

  // Long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    hold_req = 1;
    repeat (30) random_item();
    drain();
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; command = '0; load_voice = 0; load_index = '0;
    load_period = '0; load_length = '0; load_rest = 0;
    tempo_q = 10'd120; len_q[0] = 0; len_q[1] = 0; instr_q = 3'd3; end_q = 0;
    for (int i = 0; i < 2*NOTES; i++) begin
      notes_q[i] = '0;
      loaded_q[i] = 0;
    end
    for (int i = 0; i < 2; i++) begin
      pos_q[i] = 0; step_q[i] = 0; elapsed_q[i] = 0; dur_q[i] = 0; smp_q[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    test_random_phases(400);
    test_backpressure();
    test_full_lists();
    test_random_phases(950);
    quiet = 1;
    test_random_phases(1100);
    drain();
    repeat (200) @(posedge clk);
    errors += pending_results.size();

    $display("Covered %0d commands, %0d results checked, %0d note advances,", sent, checked,
             advances);
    $display("over tempo, instrument and list length settings including the extremes.");
    if (errors == 0) begin
      $display("two_voice_wavetable_sequencer_top regression: pass");
    end else begin
      $display("two_voice_wavetable_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- two_voice_wavetable_sequencer_top.f -----
design/wts_pkg.sv
design/wts_front.sv
design/wts_queue.sv
design/wts_div.sv
design/wts_back.sv
design/two_voice_wavetable_sequencer_top.sv
design/wts_checker.sv
tb/sv/two_voice_wavetable_sequencer_top_test.sv
